// File: rtl/core/complex_arithmetic_unit_core_assert.svh
// assertion macros for the complex arithmetic unit checker
// expects clk and rst_n in the scope where a macro is used
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbl failed");

// next-cycle implication, disabled in reset
`define CAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbl failed");

`endif

// File: rtl/core/cau_pkg.sv
// shared types, codes and helpers for the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QBITS         = 32;

    // command codes
    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_NEG  = 3'd4;
    localparam logic [2:0] CMD_CONJ = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } sat_t;

    // non-division result travelling beside the divider
    typedef struct packed {
        logic [31:0] y_re;
        logic [31:0] y_im;
        logic        sat;
        logic        is_div;
        logic        dz;
    } side_t;

    // one divider lane result
    typedef struct packed {
        logic [31:0] q;
        logic        ovf;
        logic        neg;
    } div_res_t;

    // clamp a wide signed value to 32 bits
    function automatic sat_t sat32(input logic signed [65:0] v);
        sat_t r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v > 66'sh0_7FFF_FFFF)
        begin
            r.sat = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end
        else if (v < -66'sh0_8000_0000)
        begin
            r.sat = 1'b1;
            r.val = 32'h8000_0000;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/cau_in_if.sv
// operand channel of the complex arithmetic unit
// no dependencies
interface cau_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;

    modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
    modport sink (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

// File: rtl/core/cau_out_if.sv
// result channel of the complex arithmetic unit
// no dependencies
interface cau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] y_re;
    logic signed [31:0] y_im;
    logic [1:0]         status;

    modport source (output valid, y_re, y_im, status, input ready);
    modport sink (input valid, y_re, y_im, status, output ready);
endinterface

// File: rtl/core/cau_front.sv
// front end: products, sums, simple results and divider operands (two stages)
// depends on cau_pkg
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [2:0]            cmd,
    input  logic signed [31:0]    a_re,
    input  logic signed [31:0]    a_im,
    input  logic signed [31:0]    b_re,
    input  logic signed [31:0]    b_im,
    output cau_pkg::side_t        side,
    output logic [63:0]           re_mag,
    output logic                  re_neg,
    output logic [63:0]           im_mag,
    output logic                  im_neg,
    output logic [63:0]           den
);

    logic [2:0]         cmd_reg;
    logic signed [63:0] arbr_reg, aibi_reg, arbi_reg, aibr_reg, brbr_reg, bibi_reg;
    cau_pkg::sat_t      cre_reg, cim_reg;
    cau_pkg::sat_t      cre_next, cim_next;
    logic signed [63:0] arbr_next, aibi_next, arbi_next, aibr_next, brbr_next, bibi_next;

    cau_pkg::side_t     side_reg, side_next;
    logic [63:0]        re_mag_reg, im_mag_reg, den_reg;
    logic [63:0]        re_mag_next, im_mag_next, den_next;
    logic               re_neg_reg, im_neg_reg, re_neg_next, im_neg_next;

    // stage one: six products and the add/sub/neg/conj results
    always_comb
    begin
        logic signed [65:0] ar, ai, br, bi;
        ar = 66'(a_re);
        ai = 66'(a_im);
        br = 66'(b_re);
        bi = 66'(b_im);
        arbr_next = a_re * b_re;
        aibi_next = a_im * b_im;
        arbi_next = a_re * b_im;
        aibr_next = a_im * b_re;
        brbr_next = b_re * b_re;
        bibi_next = b_im * b_im;
        cre_next  = '0;
        cim_next  = '0;
        case (cmd)
            cau_pkg::CMD_ADD:
            begin
                cre_next = cau_pkg::sat32(ar + br);
                cim_next = cau_pkg::sat32(ai + bi);
            end
            cau_pkg::CMD_SUB:
            begin
                cre_next = cau_pkg::sat32(ar - br);
                cim_next = cau_pkg::sat32(ai - bi);
            end
            cau_pkg::CMD_NEG:
            begin
                cre_next = cau_pkg::sat32(-ar);
                cim_next = cau_pkg::sat32(-ai);
            end
            cau_pkg::CMD_CONJ:
            begin
                cre_next = cau_pkg::sat32(ar);
                cim_next = cau_pkg::sat32(-ai);
            end
            default:
            begin
                cre_next = '0;
                cim_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg  <= cmd;
            arbr_reg <= arbr_next;
            aibi_reg <= aibi_next;
            arbi_reg <= arbi_next;
            aibr_reg <= aibr_next;
            brbr_reg <= brbr_next;
            bibi_reg <= bibi_next;
            cre_reg  <= cre_next;
            cim_reg  <= cim_next;
        end
    end

    // stage two: product sums, multiply scaling and divider operands
    always_comb
    begin
        logic signed [65:0] mre, mim, dre, dim;
        cau_pkg::sat_t      sre, sim;
        mre = 66'(arbr_reg) - 66'(aibi_reg);
        mim = 66'(arbi_reg) + 66'(aibr_reg);
        dre = 66'(arbr_reg) + 66'(aibi_reg);
        dim = 66'(aibr_reg) - 66'(arbi_reg);
        sre = cau_pkg::sat32(mre >>> FRAC_BITS);
        sim = cau_pkg::sat32(mim >>> FRAC_BITS);
        re_neg_next = dre[65];
        im_neg_next = dim[65];
        re_mag_next = dre[65] ? 64'(-dre) : dre[63:0];
        im_mag_next = dim[65] ? 64'(-dim) : dim[63:0];
        den_next    = 64'(brbr_reg) + 64'(bibi_reg);
        side_next.is_div = (cmd_reg == cau_pkg::CMD_DIV);
        side_next.dz     = (den_next == 64'd0);
        if (cmd_reg == cau_pkg::CMD_MUL)
        begin
            side_next.y_re = sre.val;
            side_next.y_im = sim.val;
            side_next.sat  = sre.sat | sim.sat;
        end
        else
        begin
            side_next.y_re = cre_reg.val;
            side_next.y_im = cim_reg.val;
            side_next.sat  = cre_reg.sat | cim_reg.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg   <= side_next;
            re_mag_reg <= re_mag_next;
            im_mag_reg <= im_mag_next;
            re_neg_reg <= re_neg_next;
            im_neg_reg <= im_neg_next;
            den_reg    <= den_next;
        end
    end

    assign side   = side_reg;
    assign re_mag = re_mag_reg;
    assign re_neg = re_neg_reg;
    assign im_mag = im_mag_reg;
    assign im_neg = im_neg_reg;
    assign den    = den_reg;

endmodule

// File: rtl/core/cau_div_lane.sv
// pipelined restoring divider, one quotient bit per stage, plus range check
// depends on cau_pkg
module cau_div_lane #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                en,
    input  logic [63:0]         mag,
    input  logic                neg,
    input  logic [63:0]         den,
    output cau_pkg::div_res_t   res
);

    localparam int QB = cau_pkg::QBITS;
    localparam int XW = (((64 + FRAC_BITS) > (64 + QB)) ? (64 + FRAC_BITS) : (64 + QB)) + 1;

    logic [XW-1:0] rem_reg [0:QB];
    logic [63:0]   den_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic          ovf_reg [0:QB];
    logic          neg_reg [0:QB];

    // entry stage: scale numerator, flag quotients of 2^32 and above
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= XW'(mag) << FRAC_BITS;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ((XW'(mag) << FRAC_BITS) >= (XW'(den) << QB));
            neg_reg[0] <= neg;
        end
    end

    // one compare and subtract per stage, most significant bit first
    for (genvar k = 0; k < QB; k++)
    begin : g_bit
        logic [XW-1:0] dsh, rem_next;
        logic [QB-1:0] q_next;
        always_comb
        begin
            dsh      = XW'(den_reg[k]) << (QB - 1 - k);
            rem_next = rem_reg[k];
            q_next   = q_reg[k];
            if (rem_reg[k] >= dsh)
            begin
                rem_next = rem_reg[k] - dsh;
                q_next[QB-1-k] = 1'b1;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= q_next;
                ovf_reg[k+1] <= ovf_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign res.q   = q_reg[QB];
    assign res.ovf = ovf_reg[QB];
    assign res.neg = neg_reg[QB];

endmodule

// File: rtl/core/complex_arithmetic_unit_core.sv
// top level of the complex arithmetic unit: front end, two divider lanes, output stage
// depends on cau_pkg, cau_in_if, cau_out_if, cau_front, cau_div_lane
//
// Complex ALU on signed fixed point operands (Q16.16 by default): add, subtract,
// multiply, divide, negate and conjugate. One transaction is accepted every cycle
// while the output is not stalled, and each gives one result. Every command takes
// the same path through the divider, a restoring divider that resolves one
// quotient bit per pipeline stage, so results leave in order. A stalled result
// holds the whole pipeline. Multiply rounds toward minus infinity, divide toward
// zero; out of range parts clamp with status 2; a zero divisor gives zero with
// status 1; commands 6 and 7 give zero with status 0.
module complex_arithmetic_unit_core #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cau_in_if.sink      op,
    cau_out_if.source   res
);

    localparam int LANE_D = cau_pkg::QBITS + 1;

    logic              en;
    cau_pkg::side_t    side_f;
    logic [63:0]       re_mag, im_mag, den;
    logic              re_neg, im_neg;
    cau_pkg::div_res_t dre, dim;

    logic              vld_reg [0:LANE_D+1];
    cau_pkg::side_t    side_reg [0:LANE_D-1];
    logic              out_vld_reg;
    logic [31:0]       y_re_reg, y_im_reg, y_re_next, y_im_next;
    logic [1:0]        st_reg, st_next;

    // whole pipeline moves when the output register is free
    assign en       = !out_vld_reg || res.ready;
    assign op.ready = en;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk    (clk),
        .en     (en),
        .cmd    (op.cmd),
        .a_re   (op.a_re),
        .a_im   (op.a_im),
        .b_re   (op.b_re),
        .b_im   (op.b_im),
        .side   (side_f),
        .re_mag (re_mag),
        .re_neg (re_neg),
        .im_mag (im_mag),
        .im_neg (im_neg),
        .den    (den)
    );

    cau_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .clk (clk),
        .en  (en),
        .mag (re_mag),
        .neg (re_neg),
        .den (den),
        .res (dre)
    );

    cau_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .clk (clk),
        .en  (en),
        .mag (im_mag),
        .neg (im_neg),
        .den (den),
        .res (dim)
    );

    // valid bits for the front end and divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LANE_D + 1; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= op.valid;
            for (int i = 1; i <= LANE_D + 1; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_vld_reg <= vld_reg[LANE_D+1];
        end
    end

    // simple results ride beside the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_f;
            for (int i = 1; i < LANE_D; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // quotient sign, clamp and result selection
    always_comb
    begin
        cau_pkg::side_t s;
        logic           sr, si;
        logic [31:0]    qr, qi;
        s  = side_reg[LANE_D-1];
        sr = 1'b0;
        si = 1'b0;
        if (dre.neg)
        begin
            sr = dre.ovf || (dre.q > 32'h8000_0000);
            qr = sr ? 32'h8000_0000 : -dre.q;
        end
        else
        begin
            sr = dre.ovf || dre.q[31];
            qr = sr ? 32'h7FFF_FFFF : dre.q;
        end
        if (dim.neg)
        begin
            si = dim.ovf || (dim.q > 32'h8000_0000);
            qi = si ? 32'h8000_0000 : -dim.q;
        end
        else
        begin
            si = dim.ovf || dim.q[31];
            qi = si ? 32'h7FFF_FFFF : dim.q;
        end
        if (s.is_div && s.dz)
        begin
            y_re_next = '0;
            y_im_next = '0;
            st_next   = cau_pkg::ST_DIVZ;
        end
        else if (s.is_div)
        begin
            y_re_next = qr;
            y_im_next = qi;
            st_next   = (sr || si) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
        else
        begin
            y_re_next = s.y_re;
            y_im_next = s.y_im;
            st_next   = s.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_re_reg <= y_re_next;
            y_im_reg <= y_im_next;
            st_reg   <= st_next;
        end
    end

    assign res.valid  = out_vld_reg;
    assign res.y_re   = y_re_reg;
    assign res.y_im   = y_im_reg;
    assign res.status = st_reg;

endmodule

// File: rtl/core/cau_checker.sv
// port-level checks for the complex arithmetic unit, bound to the top level
// depends on cau_pkg and complex_arithmetic_unit_core_assert.svh
`include "complex_arithmetic_unit_core_assert.svh"

module cau_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        op_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_y_re,
    input logic [31:0] res_y_im,
    input logic [1:0]  res_status
);

    // a waiting result stays offered
    `CAU_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid)

    // operands are taken whenever the output is not stalled
    `CAU_ASSERT_IMP(a_accept_free, !res_valid || res_ready, op_ready)

    // no status beyond saturation
    `CAU_ASSERT_IMP(a_status_code, res_valid, res_status != 2'd3)

    // a zero divisor gives a zero result
    `CAU_ASSERT_IMP(a_divz_zero, res_valid && res_status == cau_pkg::ST_DIVZ,
        res_y_re == 32'd0 && res_y_im == 32'd0)

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_ready   (op.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_y_re   (res.y_re),
    .res_y_im   (res.y_im),
    .res_status (res.status)
);
